// ===== rtl/expression_tokenizer_top_macros.svh =====
// Assertion macros shared by the expression tokenizer RTL.
`ifndef EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge outside reset.
`define EXPR_TOK_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("expression_tokenizer: invariant check failed");
// Checks that an antecedent implies a consequent in the same cycle.
`define EXPR_TOK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("expression_tokenizer: implication check failed");
`else
`define EXPR_TOK_ASSERT(label, cond)
`define EXPR_TOK_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== rtl/expr_tok_pkg.sv =====
// Shared constants and types of the expression tokenizer.
package expr_tok_pkg;

    localparam int MAX_TOKEN_LEN = 16;
    localparam int POS_BITS      = 16;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 5;
    localparam int LEN_W  = 5;
    localparam int MANT_W = 54;
    localparam int FRAC_W = 4;
    localparam int ERR_W  = 3;

    // Depth of the event queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd0;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd1;
    localparam logic [KIND_W-1:0] K_EOF     = 5'd2;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd3;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd4;
    localparam logic [KIND_W-1:0] K_LCURLY  = 5'd5;
    localparam logic [KIND_W-1:0] K_RCURLY  = 5'd6;
    localparam logic [KIND_W-1:0] K_COLON   = 5'd7;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd8;
    localparam logic [KIND_W-1:0] K_EQ      = 5'd9;
    localparam logic [KIND_W-1:0] K_NEQ     = 5'd10;
    localparam logic [KIND_W-1:0] K_LESS    = 5'd11;
    localparam logic [KIND_W-1:0] K_LEQ     = 5'd12;
    localparam logic [KIND_W-1:0] K_GREATER = 5'd13;
    localparam logic [KIND_W-1:0] K_GEQ     = 5'd14;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd15;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd16;
    localparam logic [KIND_W-1:0] K_MULT    = 5'd17;
    localparam logic [KIND_W-1:0] K_DIV     = 5'd18;
    localparam logic [KIND_W-1:0] K_POW     = 5'd19;
    localparam logic [KIND_W-1:0] K_ERROR   = 5'd20;

    // Error codes.
    localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] E_UNEXPECT  = 3'd1;
    localparam logic [ERR_W-1:0] E_NEED_EQ   = 3'd2;
    localparam logic [ERR_W-1:0] E_SECOND_DOT = 3'd3;
    localparam logic [ERR_W-1:0] E_TOO_LONG  = 3'd4;

    // Characters with a special role.
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;

    // One result beat.
    typedef struct packed {
        logic [KIND_W-1:0]   token_kind;
        logic [POS_BITS-1:0] start_pos;
        logic [LEN_W-1:0]    token_len;
        logic [MANT_W-1:0]   num_mantissa;
        logic [FRAC_W-1:0]   frac_digits;
        logic [ERR_W-1:0]    error_code;
        logic                last_of_run;
    } tok_result_t;

    // All results caused by one character: one or two.
    typedef struct packed {
        tok_result_t first;
        tok_result_t second;
        logic        two;
    } tok_event_t;

    // Queue status seen by front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/expr_tok_channels.sv =====
// Handshake channel interfaces of the expression tokenizer.
interface expr_tok_in_if import expr_tok_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              start_new;

    modport source (output valid, output char_code, output start_new, input ready);
    modport sink (input valid, input char_code, input start_new, output ready);
endinterface

interface expr_tok_out_if import expr_tok_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   token_kind;
    logic [POS_BITS-1:0] start_pos;
    logic [LEN_W-1:0]    token_len;
    logic [MANT_W-1:0]   num_mantissa;
    logic [FRAC_W-1:0]   frac_digits;
    logic [ERR_W-1:0]    error_code;
    logic                last_of_run;

    modport source (output valid, output token_kind, output start_pos, output token_len,
                    output num_mantissa, output frac_digits, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_pos, input token_len,
                  input num_mantissa, input frac_digits, input error_code,
                  input last_of_run, output ready);
endinterface

// ===== rtl/expr_tok_front.sv =====
// Front end: accepts characters, classifies them and runs the lexer state.
module expr_tok_front import expr_tok_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    expr_tok_in_if.sink in_ch,
    input  q_status_t  q_stat,
    output logic       push,
    output tok_event_t push_event
);

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] M_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] M_IDENT   = 3'd1;
    localparam logic [MODE_W-1:0] M_NUMBER  = 3'd2;
    localparam logic [MODE_W-1:0] M_BANG    = 3'd3;
    localparam logic [MODE_W-1:0] M_LESS    = 3'd4;
    localparam logic [MODE_W-1:0] M_GREATER = 3'd5;
    localparam logic [MODE_W-1:0] M_HALT    = 3'd6;

    typedef struct packed {
        logic              emit;
        tok_result_t       res;
        logic [MODE_W-1:0] mode;
        logic              start;
    } idle_out_t;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                dot_reg, dot_next;
    logic [MANT_W-1:0]   mant_reg, mant_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;

    logic [MODE_W-1:0]   eff_mode;
    logic [POS_BITS-1:0] eff_tstart;
    logic [LEN_W-1:0]    eff_len;
    logic                eff_dot;
    logic [MANT_W-1:0]   eff_mant;
    logic [FRAC_W-1:0]   eff_frac;
    logic [POS_BITS-1:0] p;
    logic [CHAR_W-1:0]   c;
    logic [3:0]          digit;
    logic                accept;
    idle_out_t           ido;
    logic                pre, run_idle, fail;
    logic [ERR_W-1:0]    fail_code;
    tok_result_t         pre_res;
    logic                len_full;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] ch);
        return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    function automatic tok_result_t make_res(input logic [KIND_W-1:0] kind,
                                             input logic [POS_BITS-1:0] pos,
                                             input logic [LEN_W-1:0] len,
                                             input logic [MANT_W-1:0] mant,
                                             input logic [FRAC_W-1:0] frac,
                                             input logic [ERR_W-1:0] err);
        tok_result_t r;
        r.token_kind   = kind;
        r.start_pos    = pos;
        r.token_len    = len;
        r.num_mantissa = mant;
        r.frac_digits  = frac;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // Decoder for the single-character tokens; the top bit flags a hit.
    function automatic logic [KIND_W:0] single_kind(input logic [CHAR_W-1:0] ch);
        logic [KIND_W:0] r;
        unique case (ch)
            8'h28:    r = {1'b1, K_LPAREN};
            8'h29:    r = {1'b1, K_RPAREN};
            8'h7B:    r = {1'b1, K_LCURLY};
            8'h7D:    r = {1'b1, K_RCURLY};
            8'h3A:    r = {1'b1, K_COLON};
            8'h2C:    r = {1'b1, K_COMMA};
            CH_EQUAL: r = {1'b1, K_EQ};
            8'h2B:    r = {1'b1, K_PLUS};
            8'h2D:    r = {1'b1, K_MINUS};
            8'h2A:    r = {1'b1, K_MULT};
            8'h2F:    r = {1'b1, K_DIV};
            CH_CARET: r = {1'b1, K_POW};
            default:  r = {1'b0, K_IDENT};
        endcase
        return r;
    endfunction

    // What a character does when no token is open.
    function automatic idle_out_t idle_step(input logic [CHAR_W-1:0] ch,
                                            input logic [POS_BITS-1:0] pos);
        idle_out_t       o;
        logic [KIND_W:0] sk;
        o      = '0;
        o.mode = M_IDLE;
        sk     = single_kind(ch);
        if (is_space(ch)) begin
            o.mode = M_IDLE;
        end else if (is_alpha(ch)) begin
            o.mode  = M_IDENT;
            o.start = 1'b1;
        end else if (is_digit(ch)) begin
            o.mode  = M_NUMBER;
            o.start = 1'b1;
        end else if (ch == CH_NUL) begin
            o.emit = 1'b1;
            o.res  = make_res(K_EOF, pos, '0, '0, '0, E_NONE);
            o.mode = M_HALT;
        end else if (ch == CH_BANG) begin
            o.mode  = M_BANG;
            o.start = 1'b1;
        end else if (ch == CH_LESS) begin
            o.mode  = M_LESS;
            o.start = 1'b1;
        end else if (ch == CH_GREATER) begin
            o.mode  = M_GREATER;
            o.start = 1'b1;
        end else if (sk[KIND_W]) begin
            o.emit = 1'b1;
            o.res  = make_res(sk[KIND_W-1:0], pos, LEN_W'(1), '0, '0, E_NONE);
        end else begin
            o.emit = 1'b1;
            o.res  = make_res(K_ERROR, pos, '0, '0, '0, E_UNEXPECT);
            o.mode = M_HALT;
        end
        return o;
    endfunction

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.char_code;
    assign digit       = c[3:0];

    // A start flag makes this character see the reset state.
    always_comb
    begin
        if (in_ch.start_new)
        begin
            eff_mode   = M_IDLE;
            eff_tstart = '0;
            eff_len    = '0;
            eff_dot    = 1'b0;
            eff_mant   = '0;
            eff_frac   = '0;
            p          = '0;
        end
        else
        begin
            eff_mode   = mode_reg;
            eff_tstart = tstart_reg;
            eff_len    = len_reg;
            eff_dot    = dot_reg;
            eff_mant   = mant_reg;
            eff_frac   = frac_reg;
            p          = pos_reg;
        end
    end

    assign ido      = idle_step(c, p);
    assign len_full = eff_len >= LEN_W'(MAX_TOKEN_LEN);

    // Lexer step: finish or extend the open token, then handle the character.
    always_comb
    begin
        mode_next   = eff_mode;
        pos_next    = pos_reg;
        tstart_next = eff_tstart;
        len_next    = eff_len;
        dot_next    = eff_dot;
        mant_next   = eff_mant;
        frac_next   = eff_frac;
        pre         = 1'b0;
        pre_res     = '0;
        run_idle    = 1'b0;
        fail        = 1'b0;
        fail_code   = E_NONE;
        if (eff_mode == M_HALT)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            pos_next = p + POS_BITS'(1);
            unique case (eff_mode)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (len_full)
                        begin
                            fail      = 1'b1;
                            fail_code = E_TOO_LONG;
                        end
                        else
                        begin
                            len_next = eff_len + LEN_W'(1);
                        end
                    end
                    else
                    begin
                        pre      = 1'b1;
                        pre_res  = make_res(K_IDENT, eff_tstart, eff_len, '0, '0, E_NONE);
                        run_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(c) || c == CH_DOT)
                    begin
                        if (c == CH_DOT && eff_dot)
                        begin
                            fail      = 1'b1;
                            fail_code = E_SECOND_DOT;
                        end
                        else if (len_full)
                        begin
                            fail      = 1'b1;
                            fail_code = E_TOO_LONG;
                        end
                        else
                        begin
                            len_next = eff_len + LEN_W'(1);
                            if (c == CH_DOT)
                            begin
                                dot_next = 1'b1;
                            end
                            else
                            begin
                                // Times ten as two shifted copies, plus the digit.
                                mant_next = {eff_mant[MANT_W-4:0], 3'b000}
                                          + {eff_mant[MANT_W-2:0], 1'b0}
                                          + MANT_W'(digit);
                                if (eff_dot)
                                begin
                                    frac_next = eff_frac + FRAC_W'(1);
                                end
                            end
                        end
                    end
                    else
                    begin
                        pre      = 1'b1;
                        pre_res  = make_res(K_NUMBER, eff_tstart, eff_len, eff_mant,
                                            eff_frac, E_NONE);
                        run_idle = 1'b1;
                    end
                end
                M_BANG:
                begin
                    if (c == CH_EQUAL)
                    begin
                        pre       = 1'b1;
                        pre_res   = make_res(K_NEQ, eff_tstart, LEN_W'(2), '0, '0, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = E_NEED_EQ;
                    end
                end
                M_LESS, M_GREATER:
                begin
                    if (c == CH_EQUAL)
                    begin
                        pre       = 1'b1;
                        pre_res   = make_res((eff_mode == M_LESS) ? K_LEQ : K_GEQ,
                                             eff_tstart, LEN_W'(2), '0, '0, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        pre      = 1'b1;
                        pre_res  = make_res((eff_mode == M_LESS) ? K_LESS : K_GREATER,
                                            eff_tstart, LEN_W'(1), '0, '0, E_NONE);
                        run_idle = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase
            if (fail)
            begin
                pre       = 1'b1;
                pre_res   = make_res(K_ERROR, p, '0, '0, '0, fail_code);
                mode_next = M_HALT;
            end
            if (run_idle)
            begin
                mode_next = ido.mode;
                if (ido.start)
                begin
                    tstart_next = p;
                    len_next    = LEN_W'(1);
                    dot_next    = 1'b0;
                    mant_next   = (ido.mode == M_NUMBER) ? MANT_W'(digit) : '0;
                    frac_next   = '0;
                end
            end
        end
    end

    // Pack the results of this character into one queue event.
    always_comb
    begin
        push_event = '0;
        if (pre && run_idle && ido.emit)
        begin
            push_event.first              = pre_res;
            push_event.second             = ido.res;
            push_event.second.last_of_run = 1'b1;
            push_event.two                = 1'b1;
        end
        else if (pre)
        begin
            push_event.first             = pre_res;
            push_event.first.last_of_run = 1'b1;
        end
        else
        begin
            push_event.first             = ido.res;
            push_event.first.last_of_run = 1'b1;
        end
    end

    assign push = accept && (pre || (run_idle && ido.emit));

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            len_reg    <= '0;
            dot_reg    <= 1'b0;
            mant_reg   <= '0;
            frac_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            len_reg    <= len_next;
            dot_reg    <= dot_next;
            mant_reg   <= mant_next;
            frac_reg   <= frac_next;
        end
    end

endmodule

// ===== rtl/expr_tok_queue.sv =====
// Short event queue between the lexer front end and the output back end.
module expr_tok_queue import expr_tok_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tok_event_t push_event,
    input  logic       pop,
    output tok_event_t head,
    output q_status_t  q_stat
);

    tok_event_t      slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == (Q_AW+1)'(Q_DEPTH);
    assign q_stat.empty = count_reg == '0;

    // Event storage; written only at the write pointer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_event;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (Q_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (Q_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/expr_tok_back.sv =====
// Back end: splits queued events into result beats behind an output register.
module expr_tok_back import expr_tok_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  tok_event_t  head,
    input  q_status_t   q_stat,
    output logic        pop,
    expr_tok_out_if.source out_ch
);

    tok_result_t out_reg;
    logic        out_valid_reg;
    logic        sub_reg;
    logic        load;

    // Load a new beat when the output register is free or being drained.
    assign load = !q_stat.empty && (!out_valid_reg || out_ch.ready);
    assign pop  = load && (sub_reg || !head.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                sub_reg       <= !sub_reg && head.two;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= sub_reg ? head.second : head.first;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.token_kind   = out_reg.token_kind;
    assign out_ch.start_pos    = out_reg.start_pos;
    assign out_ch.token_len    = out_reg.token_len;
    assign out_ch.num_mantissa = out_reg.num_mantissa;
    assign out_ch.frac_digits  = out_reg.frac_digits;
    assign out_ch.error_code   = out_reg.error_code;
    assign out_ch.last_of_run  = out_reg.last_of_run;

endmodule

// ===== rtl/expression_tokenizer_top.sv =====
// Top level of the expression tokenizer.
//
//  Channel | Direction | Beat
//  in_ch   | sink      | one character (char_code) and start_new flag
//  out_ch  | source    | one token: kind, position, length, number fields, error
//
// One character is accepted per cycle unless the queue is full; the lexer state updates
// in the cycle it is taken. Results leave one per cycle from the output register while
// out_ch is ready, so a character that ends a token and makes a token of its own yields
// two results; a four-event queue absorbs this. Results pass the queue, then out_reg.
// Reset clears the lexer to idle at position zero and empties the queue and output.
// in_ch.ready drops only while the queue is full; out_ch stalls back up into the queue.
`include "expression_tokenizer_top_macros.svh"
module expression_tokenizer_top import expr_tok_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    expr_tok_in_if.sink    in_ch,
    expr_tok_out_if.source out_ch
);

    logic       push;
    logic       pop;
    tok_event_t push_event;
    tok_event_t head;
    q_status_t  q_stat;

    expr_tok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_stat     (q_stat),
        .push       (push),
        .push_event (push_event)
    );

    expr_tok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    expr_tok_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // The front never pushes into a full queue and the back never pops an empty one.
    `EXPR_TOK_ASSERT_IMPL(a_no_push_full, push, !q_stat.full)
    `EXPR_TOK_ASSERT_IMPL(a_no_pop_empty, pop, !q_stat.empty)
    // Input is refused exactly while the queue is full.
    `EXPR_TOK_ASSERT(a_ready_tracks_queue, in_ch.ready == !q_stat.full)
    // A queued event always ends a run on its last result.
    `EXPR_TOK_ASSERT_IMPL(a_push_marks_last, push,
        (push_event.two ? push_event.second.last_of_run : push_event.first.last_of_run))

endmodule
